[rtl/motor_reversal_guard_pwm_defines.svh]
`ifndef MOTOR_REVERSAL_GUARD_PWM_DEFINES_SVH
`define MOTOR_REVERSAL_GUARD_PWM_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MRG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MRG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mrg_pkg.sv]
package mrg_pkg;

    localparam int SPEED_W = 8;
    localparam int PULSE_W = 12;
    localparam int CNT_W   = 16;
    localparam int DIR_W   = 6;
    localparam int PHASE_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic CMD_RADIO = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [1:0] LAST_BACK  = 2'd0;
    localparam logic [1:0] LAST_FRONT = 2'd1;
    localparam logic [1:0] LAST_NONE  = 2'd2;

    localparam logic [PHASE_W-1:0] PH_BRAKE  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_DWELL  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_NORMAL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_CUTOFF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_TICKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL_TICKS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_NEUTRAL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX     = 3'd6;

    // direction bit positions
    localparam int DB_LEFT_BACK   = 0;
    localparam int DB_LEFT_FRONT  = 3;
    localparam int DB_RIGHT_BACK  = 4;
    localparam int DB_RIGHT_FRONT = 5;

    localparam logic [PULSE_W-1:0] PULSE_TOP = 12'd4095;

    // floor(x / 255) = (x * DIV255_MULT) >> DIV255_SHIFT for x below 2^21
    localparam int SPAN_X_W = 21;
    localparam int DIV255_MULT_W = 24;
    localparam logic [DIV255_MULT_W-1:0] DIV255_MULT = 24'd8421505;
    localparam int DIV255_SHIFT = 31;
    localparam logic [SPAN_X_W-1:0] ROUND_HALF = 21'd127;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_cutoff;
        logic [CNT_W-1:0]   brake_ticks;
        logic [CNT_W-1:0]   dwell_ticks;
        logic [CNT_W-1:0]   silence_limit;
        logic [PULSE_W-1:0] pulse_min_us;
        logic [PULSE_W-1:0] pulse_neutral_us;
        logic [PULSE_W-1:0] pulse_max_us;
    } cfg_t;

    localparam logic [PULSE_W-1:0] PULSE_MIN_RST     = 12'd1000;
    localparam logic [PULSE_W-1:0] PULSE_NEUTRAL_RST = 12'd1500;
    localparam logic [PULSE_W-1:0] PULSE_MAX_RST     = 12'd2000;

    localparam cfg_t CFG_RST = '{
        speed_cutoff:     8'd20,
        brake_ticks:      16'd50000,
        dwell_ticks:      16'd50000,
        silence_limit:    16'd5000,
        pulse_min_us:     PULSE_MIN_RST,
        pulse_neutral_us: PULSE_NEUTRAL_RST,
        pulse_max_us:     PULSE_MAX_RST
    };

    function automatic logic [PULSE_W-1:0] sat_pulse(input logic signed [14:0] v);
        logic [PULSE_W-1:0] r;
        if (v < 15'sd0)
            r = '0;
        else if (v > 15'sd4095)
            r = PULSE_TOP;
        else
            r = v[PULSE_W-1:0];
        return r;
    endfunction

    function automatic logic [PULSE_W-1:0] span_final(input logic [PULSE_W-1:0] base,
                                                      input logic [PULSE_W-1:0] q,
                                                      input logic neg);
        logic signed [14:0] b;
        logic signed [14:0] m;
        logic signed [14:0] s;
        b = $signed({3'b000, base});
        m = $signed({3'b000, q});
        s = neg ? (b - m) : (b + m);
        return sat_pulse(s);
    endfunction

    function automatic logic [PULSE_W-1:0] mirror(input logic [PULSE_W-1:0] neutral,
                                                  input logic [PULSE_W-1:0] v);
        logic signed [14:0] d;
        d = $signed({2'b00, neutral, 1'b0}) - $signed({3'b000, v});
        return sat_pulse(d);
    endfunction

endpackage

[rtl/mrg_cfg.sv]
module mrg_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          we,
    input  logic [mrg_pkg::CFG_IDX_W-1:0] index,
    input  logic [mrg_pkg::CFG_DATA_W-1:0] data,
    output mrg_pkg::cfg_t                 cfg
);
    import mrg_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RST;
        end
        else if (we)
        begin
            unique case (index)
                REG_SPEED_CUTOFF:  cfg_reg.speed_cutoff     <= data[SPEED_W-1:0];
                REG_BRAKE_TICKS:   cfg_reg.brake_ticks      <= data[CNT_W-1:0];
                REG_DWELL_TICKS:   cfg_reg.dwell_ticks      <= data[CNT_W-1:0];
                REG_SILENCE_LIMIT: cfg_reg.silence_limit    <= data[CNT_W-1:0];
                REG_PULSE_MIN:     cfg_reg.pulse_min_us     <= data[PULSE_W-1:0];
                REG_PULSE_NEUTRAL: cfg_reg.pulse_neutral_us <= data[PULSE_W-1:0];
                REG_PULSE_MAX:     cfg_reg.pulse_max_us     <= data[PULSE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/mrg_span.sv]
module mrg_span (
    input  logic                        clk,
    input  logic                        en_mul,
    input  logic                        en_div,
    input  logic [mrg_pkg::SPEED_W-1:0] speed,
    input  logic [mrg_pkg::PULSE_W-1:0] base,
    input  logic [mrg_pkg::PULSE_W-1:0] top,
    output logic [mrg_pkg::PULSE_W-1:0] q,
    output logic                        neg
);
    import mrg_pkg::*;

    logic signed [12:0] diff;
    logic signed [21:0] prod;
    logic signed [21:0] mag;
    logic [SPAN_X_W-1:0] x;
    logic [SPAN_X_W+DIV255_MULT_W-1:0] t;

    logic [SPAN_X_W-1:0] x_reg;
    logic                neg1_reg;
    logic [PULSE_W-1:0]  q_reg;
    logic                neg2_reg;

    assign diff = $signed({1'b0, top}) - $signed({1'b0, base});
    assign prod = $signed({1'b0, speed}) * diff;
    assign mag  = prod[21] ? (22'sd0 - prod) : prod;
    assign x    = {1'b0, mag[19:0]} + ROUND_HALF;
    assign t    = x_reg * DIV255_MULT;

    always_ff @(posedge clk)
    begin
        if (en_mul)
        begin
            x_reg    <= x;
            neg1_reg <= prod[21];
        end
        if (en_div)
        begin
            q_reg    <= t[DIV255_SHIFT+PULSE_W-1:DIV255_SHIFT];
            neg2_reg <= neg1_reg;
        end
    end

    assign q   = q_reg;
    assign neg = neg2_reg;

endmodule

[rtl/mrg_side.sv]
`include "motor_reversal_guard_pwm_defines.svh"

module mrg_side (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mrg_pkg::cfg_t               cfg,
    input  logic                        upd,
    input  logic                        tick,
    input  logic [mrg_pkg::SPEED_W-1:0] speed,
    input  logic                        front,
    input  logic                        back,
    input  logic [mrg_pkg::PULSE_W-1:0] fwd_pulse,
    input  logic [mrg_pkg::PULSE_W-1:0] rev_pulse,
    output logic [mrg_pkg::PULSE_W-1:0] pulse,
    output logic [mrg_pkg::PHASE_W-1:0] phase
);
    import mrg_pkg::*;

    logic [1:0]         last_reg, last_next;
    logic               blocked_reg, blocked_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               rev;

    assign rev = (front && last_reg == LAST_BACK) || (back && last_reg == LAST_FRONT);

    always_comb
    begin
        last_next    = last_reg;
        blocked_next = blocked_reg;
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        pulse        = cfg.pulse_neutral_us;
        if (tick)
        begin
            if (cnt_reg != '0)
                cnt_next = cnt_reg - 16'd1;
        end
        else
        begin
            if (rev)
            begin
                if (!blocked_reg)
                begin
                    blocked_next = 1'b1;
                    cnt_next     = cfg.brake_ticks;
                    pulse        = cfg.pulse_min_us;
                    phase_next   = PH_BRAKE;
                end
                else
                begin
                    blocked_next = 1'b0;
                    phase_next   = PH_NORMAL;
                end
            end
            if (!blocked_next)
            begin
                if (front)
                begin
                    if (speed > cfg.speed_cutoff)
                        pulse = fwd_pulse;
                    last_next = LAST_FRONT;
                end
                else if (back)
                begin
                    if (speed > cfg.speed_cutoff)
                        pulse = rev_pulse;
                    last_next = LAST_BACK;
                end
            end
            else
            begin
                last_next = front ? LAST_FRONT : LAST_BACK;
                if (cnt_next == '0 && phase_next == PH_BRAKE)
                begin
                    cnt_next   = cfg.dwell_ticks;
                    phase_next = PH_DWELL;
                end
                else if (cnt_next == '0 && phase_next == PH_DWELL)
                begin
                    phase_next   = PH_NORMAL;
                    blocked_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg    <= LAST_NONE;
            blocked_reg <= 1'b0;
            phase_reg   <= PH_NORMAL;
            cnt_reg     <= '0;
        end
        else if (upd)
        begin
            last_reg    <= last_next;
            blocked_reg <= blocked_next;
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
        end
    end

    assign phase = phase_reg;

    `MRG_ASSERT_NOW(a_blocked_phase, blocked_reg, phase_reg != PH_NORMAL,
                    "blocked side in normal phase")
    `MRG_ASSERT_NOW(a_free_phase, !blocked_reg, phase_reg == PH_NORMAL,
                    "unblocked side outside normal phase")
    `MRG_ASSERT_NEXT(a_tick_count, upd && tick && cnt_reg != '0,
                     cnt_reg == $past(cnt_reg) - 16'd1, "countdown did not step")

endmodule

[rtl/motor_reversal_guard_pwm.sv]
// channel  direction  handshake            payload
// cfg      in         cfg_we               cfg_index, cfg_data
// in       in         in_valid / in_stall  cmd, left_speed, right_speed, direction_bits,
//                                          weapon_speed
// out      out        out_valid / out_stall left_pulse_us, right_pulse_us, weapon_pulse_us,
//                                          left_phase, right_phase, failsafe_active
//
// One transaction per cycle sustained while out_stall is low; each result passes the input,
// multiply, divide-by-255 and guard stages into the output register.
// The guard and fail-safe state updates in the same cycle as the output register, so
// consecutive items see each other's effect with no gap.
// Reset (rst_n, async low) loads default registers, neutral/min held pulses, empty pipe.
// Stages hold under out_stall; empty stages still fill, so input stalls only when full.
`include "motor_reversal_guard_pwm_defines.svh"

module motor_reversal_guard_pwm (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mrg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mrg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           cmd,
    input  logic [mrg_pkg::SPEED_W-1:0]    left_speed,
    input  logic [mrg_pkg::SPEED_W-1:0]    right_speed,
    input  logic [mrg_pkg::DIR_W-1:0]      direction_bits,
    input  logic [mrg_pkg::SPEED_W-1:0]    weapon_speed,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mrg_pkg::PULSE_W-1:0]    left_pulse_us,
    output logic [mrg_pkg::PULSE_W-1:0]    right_pulse_us,
    output logic [mrg_pkg::PULSE_W-1:0]    weapon_pulse_us,
    output logic [mrg_pkg::PHASE_W-1:0]    left_phase,
    output logic [mrg_pkg::PHASE_W-1:0]    right_phase,
    output logic                           failsafe_active
);
    import mrg_pkg::*;

    cfg_t cfg;

    logic v0_reg, v1_reg, v2_reg, res_valid_reg;
    logic r0, r1, r2, r3;
    logic fire;

    logic               s0_cmd_reg, s1_cmd_reg, s2_cmd_reg;
    logic [DIR_W-1:0]   s0_dir_reg, s1_dir_reg, s2_dir_reg;
    logic [SPEED_W-1:0] s0_ls_reg, s1_ls_reg, s2_ls_reg;
    logic [SPEED_W-1:0] s0_rs_reg, s1_rs_reg, s2_rs_reg;
    logic [SPEED_W-1:0] s0_ws_reg;

    logic [PULSE_W-1:0] q_lf, q_lb, q_rf, q_rb, q_w;
    logic               n_lf, n_lb, n_rf, n_rb, n_w;
    logic [PULSE_W-1:0] lf_pulse, lb_pulse, rf_pulse, rb_pulse, w_pulse;
    logic [PULSE_W-1:0] lp, rp;
    logic               tick;

    logic [CNT_W-1:0]   silence_reg, silence_next, silence_inc;
    logic               failsafe_reg, failsafe_next;
    logic [PULSE_W-1:0] left_reg, left_next;
    logic [PULSE_W-1:0] right_reg, right_next;
    logic [PULSE_W-1:0] weapon_reg, weapon_next;

    mrg_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    assign r3 = !res_valid_reg || !out_stall;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign r0 = !v0_reg || r1;
    assign in_stall = !r0;
    assign fire = v2_reg && r3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (r0)
                v0_reg <= in_valid;
            if (r1)
                v1_reg <= v0_reg;
            if (r2)
                v2_reg <= v1_reg;
            if (r3)
                res_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r0)
        begin
            s0_cmd_reg <= cmd;
            s0_dir_reg <= direction_bits;
            s0_ls_reg  <= left_speed;
            s0_rs_reg  <= right_speed;
            s0_ws_reg  <= weapon_speed;
        end
        if (r1)
        begin
            s1_cmd_reg <= s0_cmd_reg;
            s1_dir_reg <= s0_dir_reg;
            s1_ls_reg  <= s0_ls_reg;
            s1_rs_reg  <= s0_rs_reg;
        end
        if (r2)
        begin
            s2_cmd_reg <= s1_cmd_reg;
            s2_dir_reg <= s1_dir_reg;
            s2_ls_reg  <= s1_ls_reg;
            s2_rs_reg  <= s1_rs_reg;
        end
    end

    mrg_span u_span_lf (
        .clk (clk), .en_mul (r1), .en_div (r2), .speed (s0_ls_reg),
        .base (cfg.pulse_neutral_us), .top (cfg.pulse_max_us), .q (q_lf), .neg (n_lf)
    );
    mrg_span u_span_lb (
        .clk (clk), .en_mul (r1), .en_div (r2), .speed (s0_ls_reg),
        .base (cfg.pulse_min_us), .top (cfg.pulse_neutral_us), .q (q_lb), .neg (n_lb)
    );
    mrg_span u_span_rf (
        .clk (clk), .en_mul (r1), .en_div (r2), .speed (s0_rs_reg),
        .base (cfg.pulse_neutral_us), .top (cfg.pulse_max_us), .q (q_rf), .neg (n_rf)
    );
    mrg_span u_span_rb (
        .clk (clk), .en_mul (r1), .en_div (r2), .speed (s0_rs_reg),
        .base (cfg.pulse_min_us), .top (cfg.pulse_neutral_us), .q (q_rb), .neg (n_rb)
    );
    mrg_span u_span_w (
        .clk (clk), .en_mul (r1), .en_div (r2), .speed (s0_ws_reg),
        .base (cfg.pulse_min_us), .top (cfg.pulse_max_us), .q (q_w), .neg (n_w)
    );

    assign lf_pulse = span_final(cfg.pulse_neutral_us, q_lf, n_lf);
    assign lb_pulse = span_final(cfg.pulse_min_us, q_lb, n_lb);
    assign rf_pulse = span_final(cfg.pulse_neutral_us, q_rf, n_rf);
    assign rb_pulse = span_final(cfg.pulse_min_us, q_rb, n_rb);
    assign w_pulse  = span_final(cfg.pulse_min_us, q_w, n_w);

    assign tick = (s2_cmd_reg == CMD_TICK);

    mrg_side u_left (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .upd       (fire),
        .tick      (tick),
        .speed     (s2_ls_reg),
        .front     (s2_dir_reg[DB_LEFT_FRONT]),
        .back      (s2_dir_reg[DB_LEFT_BACK]),
        .fwd_pulse (lf_pulse),
        .rev_pulse (lb_pulse),
        .pulse     (lp),
        .phase     (left_phase)
    );

    mrg_side u_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .upd       (fire),
        .tick      (tick),
        .speed     (s2_rs_reg),
        .front     (s2_dir_reg[DB_RIGHT_FRONT]),
        .back      (s2_dir_reg[DB_RIGHT_BACK]),
        .fwd_pulse (rf_pulse),
        .rev_pulse (rb_pulse),
        .pulse     (rp),
        .phase     (right_phase)
    );

    assign silence_inc = (silence_reg == '1) ? silence_reg : silence_reg + 16'd1;

    always_comb
    begin
        silence_next  = silence_reg;
        failsafe_next = failsafe_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        weapon_next   = weapon_reg;
        if (!tick)
        begin
            silence_next  = '0;
            failsafe_next = 1'b0;
            left_next     = lp;
            right_next    = mirror(cfg.pulse_neutral_us, rp);
            weapon_next   = w_pulse;
        end
        else
        begin
            silence_next = silence_inc;
            if (silence_inc > cfg.silence_limit)
            begin
                failsafe_next = 1'b1;
                left_next     = cfg.pulse_neutral_us;
                right_next    = mirror(cfg.pulse_neutral_us, cfg.pulse_neutral_us);
                weapon_next   = cfg.pulse_min_us;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            silence_reg  <= '0;
            failsafe_reg <= 1'b0;
            left_reg     <= PULSE_NEUTRAL_RST;
            right_reg    <= PULSE_NEUTRAL_RST;
            weapon_reg   <= PULSE_MIN_RST;
        end
        else if (fire)
        begin
            silence_reg  <= silence_next;
            failsafe_reg <= failsafe_next;
            left_reg     <= left_next;
            right_reg    <= right_next;
            weapon_reg   <= weapon_next;
        end
    end

    assign out_valid       = res_valid_reg;
    assign left_pulse_us   = left_reg;
    assign right_pulse_us  = right_reg;
    assign weapon_pulse_us = weapon_reg;
    assign failsafe_active = failsafe_reg;

    `MRG_ASSERT_NOW(a_failsafe_silence, failsafe_reg, silence_reg != '0,
                    "fail-safe set with no silence counted")
    `MRG_ASSERT_NEXT(a_stage_hold, v2_reg && !r3, v2_reg && $stable(s2_cmd_reg),
                     "guard stage lost a held transaction")
    `MRG_ASSERT_NEXT(a_fire_result, fire, res_valid_reg,
                     "processed transaction gave no result")

endmodule
